// ===== src/grid_fire_dilation_3x3_assert.svh =====
// Assertion helpers used by grid_fire_dilation_3x3; clock and reset are the block's own.
`ifndef GRID_FIRE_DILATION_3X3_ASSERT_SVH
`define GRID_FIRE_DILATION_3X3_ASSERT_SVH

// same-cycle implication
`define GFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gfd_pkg.sv =====
`timescale 1ns / 1ps
package gfd_pkg;

   localparam logic [7:0] BURN_CODE = 8'd70;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS = 2'd1;

   localparam int CSR_DATA_W = 16;
   localparam int COLS_REG_W = 11;
   localparam int ROWS_REG_W = 16;

   localparam logic [COLS_REG_W-1:0] GRID_COLS_RESET = 11'd64;
   localparam logic [ROWS_REG_W-1:0] GRID_ROWS_RESET = 16'd64;

   typedef struct packed {
      logic       drop;
      logic       emit;
      logic       last;
      logic [8:0] allowed;
   } gfd_scan_type;

endpackage

// ===== src/gfd_ram.sv =====
`timescale 1ns / 1ps
module gfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/gfd_scan.sv =====
`timescale 1ns / 1ps
module gfd_scan
   import gfd_pkg::*;
#(
   parameter int MAX_COLS = 1024
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        restart,
   input  logic                                        step,
   input  logic                                        pad,
   input  logic [COLS_REG_W-1:0]                       grid_cols,
   input  logic [ROWS_REG_W-1:0]                       grid_rows,
   output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] ic,
   output gfd_scan_type                                ctrl
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int FW = $clog2(MAX_COLS + 2);

   logic [AW-1:0]         in_col_ff, in_col_in;
   logic [AW-1:0]         col_ff, col_in;
   logic [ROWS_REG_W-1:0] row_ff, row_in;
   logic [FW-1:0]         fill_ff, fill_in;

   logic [CW-1:0]         cols;
   logic [ROWS_REG_W-1:0] rows;
   logic                  filling;
   logic                  right_ok;
   logic                  bottom_ok;
   logic [2:0]            rowmask;

   always_comb begin
      if (grid_cols == '0) begin
         cols = CW'(1);
      end else if (32'(grid_cols) > MAX_COLS) begin
         cols = CW'(MAX_COLS);
      end else begin
         cols = CW'(grid_cols);
      end
      rows = (grid_rows == '0) ? ROWS_REG_W'(1) : grid_rows;

      ic = (CW'(in_col_ff) < cols) ? in_col_ff : '0;

      filling   = fill_ff <= FW'(cols);
      right_ok  = CW'(col_ff) < (cols - CW'(1));
      bottom_ok = row_ff < (rows - ROWS_REG_W'(1));
      rowmask   = {row_ff != '0, 1'b1, bottom_ok};

      ctrl.drop    = pad && (fill_ff == '0) && (row_ff == '0) && (col_ff == '0);
      ctrl.emit    = !filling;
      ctrl.last    = !filling && !bottom_ok && !right_ok;
      ctrl.allowed = {(col_ff != '0) ? rowmask : 3'b000, rowmask,
                      right_ok ? rowmask : 3'b000};

      in_col_in = in_col_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      fill_in   = fill_ff;
      if (restart) begin
         in_col_in = '0;
         col_in    = '0;
         row_in    = '0;
         fill_in   = '0;
      end else if (step && !ctrl.drop) begin
         if (ctrl.last) begin
            in_col_in = '0;
            col_in    = '0;
            row_in    = '0;
            fill_in   = '0;
         end else begin
            in_col_in = ((CW'(ic) + CW'(1)) >= cols) ? '0 : ic + AW'(1);
            if (filling) begin
               fill_in = fill_ff + FW'(1);
            end else if (!right_ok) begin
               col_in = '0;
               row_in = row_ff + ROWS_REG_W'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         fill_ff   <= '0;
      end else begin
         in_col_ff <= in_col_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== src/grid_fire_dilation_3x3.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_action, req_cell_code
// rsp       out        rsp_valid / rsp_ready  rsp_cell_result, rsp_frame_last
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One request per cycle unless rsp stalls; results pass stage s1, then rsp registers.
// Results trail requests by grid_cols+1 requests (line buffer fill).
// Line buffers sit in one 16-bit RAM with a registered read; a write in the cycle
// of a read to the same column is forwarded.
// Reset is synchronous and needs no clearing pass: unwritten columns only feed
// masked window rows. Requests stall only while a result waits in the output register.
module grid_fire_dilation_3x3
   import gfd_pkg::*;
#(
   parameter int MAX_COLS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [7:0]             req_cell_code,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_cell_result,
   output logic                   rsp_frame_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [COLS_REG_W-1:0] grid_cols_ff;
   logic [ROWS_REG_W-1:0] grid_rows_ff;
   logic                  csr_write;
   logic                  restart;

   logic                  accept;
   logic [AW-1:0]         ic;
   gfd_scan_type          ctrl;

   logic                  s1_valid_ff;
   gfd_scan_type          s1_ctrl_ff;
   logic [7:0]            s1_code_ff;
   logic [AW-1:0]         s1_ic_ff;
   logic                  s1_adv;

   logic                  fwd_ff;
   logic [15:0]           fwd_data_ff;
   logic [15:0]           ram_rdata;
   logic [15:0]           lines;
   logic [15:0]           wdata;

   logic [8:0]            window_ff, window_in;
   logic [7:0]            center_ff;
   logic [7:0]            result;

   logic                  rsp_valid_ff;
   logic [7:0]            rsp_cell_result_ff;
   logic                  rsp_frame_last_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write &&
                      (csr_index == CSR_GRID_COLS || csr_index == CSR_GRID_ROWS);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_COLS_RESET;
         grid_rows_ff <= GRID_ROWS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata[COLS_REG_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[ROWS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign s1_adv    = s1_valid_ff && (!s1_ctrl_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   gfd_scan #(
      .MAX_COLS(MAX_COLS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .step     (accept),
      .pad      (req_action),
      .grid_cols(grid_cols_ff),
      .grid_rows(grid_rows_ff),
      .ic       (ic),
      .ctrl     (ctrl)
   );

   gfd_ram #(
      .WIDTH(16),
      .DEPTH(MAX_COLS)
   ) u_lines (
      .clock(clock),
      .we   (s1_adv),
      .waddr(s1_ic_ff),
      .wdata(wdata),
      .re   (accept),
      .raddr(ic),
      .rdata(ram_rdata)
   );

   always_comb begin
      lines     = fwd_ff ? fwd_data_ff : ram_rdata;
      wdata     = {lines[7:0], s1_code_ff};
      window_in = {window_ff[5:0], lines[15:8] == BURN_CODE, lines[7:0] == BURN_CODE,
                   s1_code_ff == BURN_CODE};
      result    = ((window_in & s1_ctrl_ff.allowed) != '0) ? BURN_CODE : center_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept && !ctrl.drop) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff  <= ctrl;
         s1_code_ff  <= req_action ? 8'd0 : req_cell_code;
         s1_ic_ff    <= ic;
         fwd_ff      <= s1_adv && (s1_ic_ff == ic);
         fwd_data_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         window_ff <= '0;
         center_ff <= '0;
      end else if (s1_adv) begin
         if (s1_ctrl_ff.last) begin
            window_ff <= '0;
            center_ff <= '0;
         end else begin
            window_ff <= window_in;
            center_ff <= lines[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_ctrl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctrl_ff.emit) begin
         rsp_cell_result_ff <= result;
         rsp_frame_last_ff  <= s1_ctrl_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_result = rsp_cell_result_ff;
   assign rsp_frame_last  = rsp_frame_last_ff;

`include "grid_fire_dilation_3x3_assert.svh"

   `GFD_ASSERT_NOW(a_stall_cause, s1_valid_ff && !s1_adv, rsp_valid_ff && !rsp_ready, "stage stalled without blocked result")
   `GFD_ASSERT_NOW(a_ready_empty, !s1_valid_ff, req_ready, "request refused with empty stage")
   `GFD_ASSERT_NEXT(a_stage_load, accept && !ctrl.drop, s1_valid_ff, "accepted request lost")
   `GFD_ASSERT_NEXT(a_frame_clear, s1_adv && s1_ctrl_ff.last, window_ff == '0 && center_ff == '0, "window not cleared at frame end")
   `GFD_ASSERT_NEXT(a_result_load, s1_adv && s1_ctrl_ff.emit, rsp_valid_ff, "result not presented")

endmodule

// ===== tb/fire_spread_check.sv =====
`timescale 1ns / 1ps
module fire_spread_check
   import gfd_pkg::*;
#(
   parameter int MAX_COLS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_action,
   input  logic [7:0]             req_cell_code,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_cell_result,
   input  logic                   rsp_frame_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     cells_due
);

   typedef struct packed {
      logic [7:0] cell_result;
      logic       frame_last;
   } burn_cell_type;

   burn_cell_type         due_cells[$];
   burn_cell_type         due_cell;
   logic [7:0]            upper_row [MAX_COLS];
   logic [7:0]            middle_row [MAX_COLS];
   logic [8:0]            burn_bits;
   logic [7:0]            centre;
   logic [COLS_REG_W-1:0] cols_reg;
   logic [ROWS_REG_W-1:0] rows_reg;
   int unsigned           out_row;
   int unsigned           out_col;
   int unsigned           emitted;
   int unsigned           in_col;
   int unsigned           fill;
   int                    mismatches = 0;

   function automatic int unsigned active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return cols_reg;
   endfunction

   function automatic void restart_frame();
      burn_bits = '0;
      centre = '0;
      out_row = 0;
      out_col = 0;
      emitted = 0;
      in_col = 0;
      fill = 0;
   endfunction

   task automatic spread_fire(input logic pad, input logic [7:0] code_in);
      int unsigned   ncols;
      int unsigned   nrows;
      int unsigned   ic;
      logic [7:0]    code;
      logic [7:0]    prev_centre;
      logic [2:0]    colbits;
      logic [2:0]    row_ok;
      logic [8:0]    allowed;
      burn_cell_type next_cell;
      ncols = active_cols();
      nrows = (rows_reg == 0) ? 1 : rows_reg;
      code = pad ? 8'd0 : code_in;
      // drop pads that arrive before a frame starts
      if (!(pad && fill == 0 && emitted == 0)) begin
         ic = (in_col < ncols) ? in_col : 0;
         colbits = {upper_row[ic] == BURN_CODE, middle_row[ic] == BURN_CODE,
                    code == BURN_CODE};
         prev_centre = centre;
         centre = middle_row[ic];
         upper_row[ic] = middle_row[ic];
         middle_row[ic] = code;
         burn_bits = {burn_bits[5:0], colbits};
         in_col = (ic + 1 >= ncols) ? 0 : ic + 1;
         if (fill < ncols + 1) begin
            fill++;
         end else begin
            row_ok = {out_row > 0, 1'b1, out_row + 1 < nrows};
            allowed = {(out_col > 0) ? row_ok : 3'b000, row_ok,
                       (out_col + 1 < ncols) ? row_ok : 3'b000};
            next_cell.cell_result = |(burn_bits & allowed) ? BURN_CODE : prev_centre;
            next_cell.frame_last = (emitted + 1 >= nrows * ncols);
            due_cells.push_back(next_cell);
            if (next_cell.frame_last) begin
               restart_frame();
            end else begin
               emitted++;
               out_col++;
               if (out_col >= ncols) begin
                  out_col = 0;
                  out_row++;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COLS; i++) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         due_cells.delete();
         cols_reg = GRID_COLS_RESET;
         rows_reg = GRID_ROWS_RESET;
         restart_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_COLS: begin
                  cols_reg = csr_wdata[COLS_REG_W-1:0];
                  restart_frame();
               end
               CSR_GRID_ROWS: begin
                  rows_reg = csr_wdata[ROWS_REG_W-1:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) spread_fire(req_action, req_cell_code);
         if (rsp_valid && rsp_ready) begin
            if (due_cells.size() == 0) begin
               mismatches++;
               $error("unexpected result: cell_result %0d frame_last %0d",
                      rsp_cell_result, rsp_frame_last);
            end else begin
               due_cell = due_cells.pop_front();
               if (rsp_cell_result !== due_cell.cell_result) begin
                  mismatches++;
                  $error("cell_result: expected %0d, got %0d",
                         due_cell.cell_result, rsp_cell_result);
               end
               if (rsp_frame_last !== due_cell.frame_last) begin
                  mismatches++;
                  $error("frame_last: expected %0d, got %0d",
                         due_cell.frame_last, rsp_frame_last);
               end
            end
         end
      end
      fail_count <= mismatches;
      cells_due <= due_cells.size();
   end

endmodule

// ===== tb/grid_fire_dilation_3x3_test.sv =====
`timescale 1ns / 1ps
module grid_fire_dilation_3x3_test;
   import gfd_pkg::*;

   localparam int GRID_MAX_COLS = 64;
   localparam logic ACT_CELL = 1'b0;
   localparam logic ACT_PAD = 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_REQUESTS = 720;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_action;
   logic [7:0]             req_cell_code;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_cell_result;
   logic                   rsp_frame_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     cells_due;
   bit                     steady = 1'b0;
   int                     requests_sent = 0;
   int                     idle_cycles = 0;
   int                     rsp_hold = 0;
   int                     cols_now;
   int                     rows_now;

   grid_fire_dilation_3x3 #(.MAX_COLS(GRID_MAX_COLS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_cell_code   (req_cell_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_result (rsp_cell_result),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   fire_spread_check #(.MAX_COLS(GRID_MAX_COLS)) spread_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_cell_code   (req_cell_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_result (rsp_cell_result),
      .rsp_frame_last  (rsp_frame_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .cells_due       (cells_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] random_code(input int burn_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < burn_pct) return BURN_CODE;
      if (roll < burn_pct + 5) return 8'($urandom_range(BURN_CODE - 1, BURN_CODE + 1));
      return 8'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[grid_fire_dilation_3x3] ERROR");
         $finish;
      end
   end

   task automatic send_request(input logic action, input logic [7:0] code);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_cell_code <= code;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (cells_due != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(input int ncols, input int nrows, input int burn_pct);
      int pos;
      for (pos = 0; pos < ncols * nrows; pos++) begin
         if ($urandom_range(0, 99) < 3)
            send_request(ACT_PAD, random_code(burn_pct));
         else
            send_request(ACT_CELL, random_code(burn_pct));
         if ($urandom_range(0, 999) < 3) drain_results();
      end
      for (pos = 0; pos <= ncols; pos++)
         send_request(($urandom_range(0, 9) == 0) ? ACT_CELL : ACT_PAD,
                      random_code(burn_pct));
   endtask

   initial begin
      int k;
      int count;
      int burn_pct;
      int stop_at;
      int roll;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_CELL;
      req_cell_code <= 8'd0;
      csr_valid <= 1'b0;
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(ACT_PAD, BURN_CODE);
      for (k = 0; k < 72; k++) send_request(ACT_CELL, random_code(15));

      write_reg(CSR_GRID_COLS, 16'd3);
      write_reg(CSR_GRID_ROWS, 16'd3);
      send_request(ACT_PAD, 8'd0);
      send_request(ACT_CELL, BURN_CODE);
      send_request(ACT_CELL, 8'd0);
      send_request(ACT_CELL, 8'd255);
      send_request(ACT_CELL, BURN_CODE - 8'd1);
      send_request(ACT_PAD, BURN_CODE);
      send_request(ACT_CELL, BURN_CODE + 8'd1);
      send_request(ACT_CELL, 8'd1);
      send_request(ACT_CELL, 8'd128);
      send_request(ACT_CELL, BURN_CODE);
      send_request(ACT_PAD, 8'd0);
      send_request(ACT_CELL, BURN_CODE);
      send_request(ACT_PAD, 8'd255);
      send_request(ACT_CELL, 8'd255);
      for (k = 0; k < 9; k++) begin
         send_request(ACT_CELL, (k == 4) ? BURN_CODE : 8'd42);
         if (k == 4) drain_results();
      end
      for (k = 0; k < 4; k++) send_request(ACT_PAD, 8'd0);

      write_reg(CSR_GRID_COLS, 16'd0);
      write_reg(CSR_GRID_ROWS, 16'd0);
      send_request(ACT_CELL, BURN_CODE);
      send_request(ACT_PAD, 8'd0);
      send_request(ACT_CELL, 8'd7);
      send_request(ACT_CELL, 8'd9);
      send_request(ACT_PAD, BURN_CODE);
      send_request(ACT_PAD, 8'd0);

      write_reg(CSR_GRID_COLS, 16'd2);
      write_reg(CSR_GRID_ROWS, 16'd2);
      send_request(ACT_CELL, 8'd0);
      send_request(ACT_CELL, BURN_CODE);
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      send_request(ACT_CELL, 8'd200);
      send_request(ACT_CELL, 8'd3);
      for (k = 0; k < 3; k++) send_request(ACT_PAD, 8'd0);

      write_reg(CSR_GRID_COLS, 16'(GRID_MAX_COLS));
      write_reg(CSR_GRID_ROWS, 16'hFFFF);
      for (k = 0; k < GRID_MAX_COLS + 41; k++) send_request(ACT_CELL, random_code(10));
      write_reg(CSR_GRID_COLS, 16'h07FF);
      write_reg(CSR_GRID_ROWS, 16'd1);
      for (k = 0; k < 16; k++) send_request(ACT_CELL, random_code(10));

      rows_now = 1;
      stop_at = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < stop_at) begin
         steady = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 50) cols_now = $urandom_range(1, 4);
         else if (roll < 85) cols_now = $urandom_range(5, 12);
         else if (roll < 96) cols_now = $urandom_range(13, 40);
         else cols_now = 0;
         write_reg(CSR_GRID_COLS, 16'(cols_now));
         if (cols_now == 0) cols_now = 1;
         if ($urandom_range(0, 9) < 7) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) rows_now = $urandom_range(1, 4);
            else if (roll < 90) rows_now = $urandom_range(5, 10);
            else rows_now = 0;
            write_reg(CSR_GRID_ROWS, 16'(rows_now));
            if (rows_now == 0) rows_now = 1;
         end
         burn_pct = $urandom_range(0, 30);
         if ($urandom_range(0, 9) == 0) begin
            count = $urandom_range(1, 3);
            for (k = 0; k < count; k++) send_request(ACT_PAD, random_code(burn_pct));
         end
         count = $urandom_range(1, 3);
         for (k = 0; k < count; k++) send_frame(cols_now, rows_now, burn_pct);
         if ($urandom_range(0, 6) == 0) begin
            count = $urandom_range(1, cols_now * rows_now + cols_now);
            for (k = 0; k < count; k++) send_request(ACT_CELL, random_code(burn_pct));
         end
      end

      steady = 1'b0;
      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[grid_fire_dilation_3x3] OK");
      else
         $display("[grid_fire_dilation_3x3] ERROR");
      $finish;
   end

endmodule
